[hdl/sfdl_pkg.sv]
// shared types, constants and the soft-clip table for the stereo feedback delay
// no dependencies; imported by every module of the block except sfdl_ram
package sfdl_pkg;

  localparam int DELAY_DEPTH_DEF = 131072;

  localparam int SAMPLE_W = 16;
  localparam int DELAY_W  = 17;
  localparam int GAIN_W   = 15;
  localparam int MIX_W    = 16;
  localparam int CFG_W    = 17;
  localparam int CFG_IDX_W = 3;
  localparam int LP_W     = 24;

  localparam logic [DELAY_W-1:0] DELAY_LEFT_RST    = 17'd9084;
  localparam logic [DELAY_W-1:0] DELAY_RIGHT_RST   = 17'd9901;
  localparam logic [GAIN_W-1:0]  FEEDBACK_GAIN_RST = 15'd4424;
  localparam logic [GAIN_W-1:0]  LOWPASS_COEFF_RST = 15'd22282;
  localparam logic [MIX_W-1:0]   DRY_GAIN_RST      = 16'd27034;
  localparam logic [MIX_W-1:0]   WET_GAIN_RST      = 16'd11469;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY_LEFT    = 3'd0,
    REG_DELAY_RIGHT   = 3'd1,
    REG_FEEDBACK_GAIN = 3'd2,
    REG_LOWPASS_COEFF = 3'd3,
    REG_DRY_GAIN      = 3'd4,
    REG_WET_GAIN      = 3'd5
  } cfg_idx_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_in;   // item accepted, ram read issued
    logic mult;      // lowpass, dry and wet products
    logic lp;        // lowpass update, output mix
    logic fb;        // feedback product
    logic tab;       // soft-clip table lookup
    logic write;     // interpolate, write stores, advance position
    logic load_out;  // move mix into output register
  } dp_cmd_t;

  // soft-clip table: 257 points of tanh over [-2,2] in Q1.15
  localparam int TANH_POINTS = 257;
  localparam longint EXP_STEP_Q24 = 64'd17309782;
  localparam longint ONE_Q24 = 64'd16777216;

  typedef logic signed [SAMPLE_W-1:0] tanh_tab_t [0:TANH_POINTS-1];

  // quotient of two positive values when it stays below 2^16, by shift and subtract
  function automatic longint quot16(input longint num, input longint den);
    longint rem;
    longint q;
    rem = num;
    q = 0;
    for (int b = 15; b >= 0; b--) begin
      if (rem >= (den << b)) begin
        rem = rem - (den << b);
        q = q + (64'sd1 << b);
      end
    end
    return q;
  endfunction

  function automatic tanh_tab_t build_tanh();
    tanh_tab_t t;
    longint e;
    longint num;
    longint den;
    longint v;
    e = ONE_Q24;
    t[128] = '0;
    for (int m = 1; m <= 128; m++) begin
      e = (e * EXP_STEP_Q24) >>> 24;
      num = (e - ONE_Q24) * 65536 + (e + ONE_Q24);
      den = 2 * (e + ONE_Q24);
      v = quot16(num, den);
      t[128 + m] = SAMPLE_W'(v);
      t[128 - m] = SAMPLE_W'(-v);
    end
    return t;
  endfunction

  localparam tanh_tab_t TANH_TAB = build_tanh();

endpackage

[hdl/sfdl_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module sfdl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/sfdl_ctrl.sv]
// sequencer for one stereo item: read, lowpass, feedback, table, write, output
// depends on sfdl_pkg
module sfdl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output sfdl_pkg::dp_cmd_t cmd
);
  import sfdl_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_READ  = 7'b0000010,
    ST_LP    = 7'b0000100,
    ST_FB    = 7'b0001000,
    ST_TAB   = 7'b0010000,
    ST_WRITE = 7'b0100000,
    ST_HOLD  = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   out_valid;
  logic   out_free;

  assign out_free = !out_valid || m_tready;
  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;

  always_comb begin
    cmd.load_in  = s_tvalid && s_tready;
    cmd.mult     = (state == ST_READ);
    cmd.lp       = (state == ST_LP);
    cmd.fb       = (state == ST_FB);
    cmd.tab      = (state == ST_TAB);
    cmd.write    = (state == ST_WRITE);
    cmd.load_out = ((state == ST_WRITE) || (state == ST_HOLD)) && out_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (s_tvalid) state_next = ST_READ;
      ST_READ:  state_next = ST_LP;
      ST_LP:    state_next = ST_FB;
      ST_FB:    state_next = ST_TAB;
      ST_TAB:   state_next = ST_WRITE;
      ST_WRITE: state_next = out_free ? ST_IDLE : ST_HOLD;
      ST_HOLD:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[hdl/sfdl_datapath.sv]
// two-lane datapath: config registers, delay stores, lowpass, soft clip, mix
// depends on sfdl_pkg and sfdl_ram
module sfdl_datapath #(
  parameter int DELAY_DEPTH = sfdl_pkg::DELAY_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [sfdl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfdl_pkg::CFG_W-1:0]     cfg_data,
  input  logic [31:0]                    in_data,
  output logic [31:0]                    out_data,
  input  sfdl_pkg::dp_cmd_t              cmd
);
  import sfdl_pkg::*;

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int CW = ((AW > DELAY_W) ? AW : DELAY_W) + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DELAY_DEPTH);

  logic [DELAY_W-1:0] delay_cfg [2];
  logic [GAIN_W-1:0]  feedback_gain;
  logic [GAIN_W-1:0]  lowpass_coeff;
  logic [MIX_W-1:0]   dry_gain;
  logic [MIX_W-1:0]   wet_gain;

  logic [AW-1:0] write_position;
  logic          filled;   // every store entry has been written once
  logic [15:0]   lane_out [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_cfg[0]  <= DELAY_LEFT_RST;
      delay_cfg[1]  <= DELAY_RIGHT_RST;
      feedback_gain <= FEEDBACK_GAIN_RST;
      lowpass_coeff <= LOWPASS_COEFF_RST;
      dry_gain      <= DRY_GAIN_RST;
      wet_gain      <= WET_GAIN_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_DELAY_LEFT:    delay_cfg[0]  <= cfg_data[DELAY_W-1:0];
        REG_DELAY_RIGHT:   delay_cfg[1]  <= cfg_data[DELAY_W-1:0];
        REG_FEEDBACK_GAIN: feedback_gain <= cfg_data[GAIN_W-1:0];
        REG_LOWPASS_COEFF: lowpass_coeff <= cfg_data[GAIN_W-1:0];
        REG_DRY_GAIN:      dry_gain      <= cfg_data[MIX_W-1:0];
        REG_WET_GAIN:      wet_gain      <= cfg_data[MIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_position <= '0;
      filled         <= 1'b0;
    end else if (cmd.write) begin
      if ({1'b0, write_position} == (AW+1)'(DELAY_DEPTH - 1)) begin
        write_position <= '0;
        filled         <= 1'b1;
      end else begin
        write_position <= write_position + 1'b1;
      end
    end
  end

  for (genvar ch = 0; ch < 2; ch++) begin : g_lane
    logic [CW-1:0]          d_ext;
    logic [AW-1:0]          d_clamp;
    logic [AW:0]            rd_sum;
    logic [AW-1:0]          rd_addr;
    logic                   rd_ok;
    logic                   rd_ok_q;
    logic signed [15:0]     in_q;
    logic [15:0]            ram_q;
    logic signed [15:0]     del;
    logic signed [24:0]     diff;
    logic signed [40:0]     lp_prod;
    logic signed [32:0]     dry_prod;
    logic signed [32:0]     wet_prod;
    logic signed [LP_W-1:0] lp;
    logic signed [25:0]     lp_sum;
    logic signed [33:0]     mix_sum;
    logic signed [18:0]     mix_sh;
    logic signed [15:0]     mix;
    logic signed [39:0]     fb_prod;
    logic signed [16:0]     fb_term;
    logic signed [17:0]     x;
    logic signed [17:0]     u;
    logic [7:0]             seg;
    logic [8:0]             seg_hi;
    logic signed [15:0]     ta;
    logic signed [15:0]     tb;
    logic signed [15:0]     tab_a;
    logic signed [16:0]     tab_d;
    logic [8:0]             tab_f;
    logic                   clip_lo;
    logic                   clip_hi;
    logic signed [26:0]     ip;
    logic signed [17:0]     y;
    logic signed [15:0]     wdata;

    // read address: zero delay acts as one, too long acts as depth minus one
    always_comb begin
      d_ext = CW'(delay_cfg[ch]);
      if (d_ext == '0) begin
        d_clamp = AW'(1);
      end else if (d_ext >= DEPTH_C) begin
        d_clamp = AW'(DELAY_DEPTH - 1);
      end else begin
        d_clamp = d_ext[AW-1:0];
      end
      if (write_position >= d_clamp) begin
        rd_sum = {1'b0, write_position} - {1'b0, d_clamp};
      end else begin
        rd_sum = {1'b0, write_position} + (AW+1)'(DELAY_DEPTH) - {1'b0, d_clamp};
      end
      rd_addr = rd_sum[AW-1:0];
      // entries not yet written read as zero
      rd_ok = filled || (rd_addr < write_position);
    end

    sfdl_ram #(
      .WIDTH(SAMPLE_W),
      .DEPTH(DELAY_DEPTH)
    ) u_store (
      .clk  (clk),
      .we   (cmd.write),
      .waddr(write_position),
      .wdata(wdata),
      .re   (cmd.load_in),
      .raddr(rd_addr),
      .rdata(ram_q)
    );

    always_comb begin
      del     = rd_ok_q ? $signed(ram_q) : 16'sd0;
      diff    = $signed({del[15], del, 8'b0}) - $signed({lp[LP_W-1], lp});
      lp_sum  = $signed({{2{lp[LP_W-1]}}, lp}) + $signed(lp_prod[40:15]);
      mix_sum = $signed({dry_prod[32], dry_prod}) + $signed({wet_prod[32], wet_prod})
                + 34'sd16384;
      mix_sh  = $signed(mix_sum[33:15]);
      if (mix_sh > 19'sd32767) begin
        mix = 16'sd32767;
      end else if (mix_sh < -19'sd32768) begin
        mix = -16'sd32768;
      end else begin
        mix = mix_sh[15:0];
      end
      fb_term = $signed(fb_prod[39:23]);
      x       = $signed({{2{in_q[15]}}, in_q}) + $signed({fb_term[16], fb_term});
      u       = x + 18'sd65536;
      seg     = u[16:9];
      seg_hi  = {1'b0, seg} + 9'd1;
      ta      = TANH_TAB[seg];
      tb      = TANH_TAB[seg_hi];
      ip      = tab_d * $signed({1'b0, tab_f});
      y       = $signed({{2{tab_a[15]}}, tab_a}) + $signed(ip[26:9]);
      if (clip_lo) begin
        wdata = TANH_TAB[0];
      end else if (clip_hi) begin
        wdata = TANH_TAB[TANH_POINTS-1];
      end else begin
        wdata = y[15:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        lp <= '0;
      end else if (cmd.lp) begin
        lp <= lp_sum[LP_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.load_in) begin
        in_q    <= $signed(in_data[16*ch +: 16]);
        rd_ok_q <= rd_ok;
      end
      if (cmd.mult) begin
        lp_prod  <= diff * $signed({1'b0, lowpass_coeff});
        dry_prod <= in_q * $signed({1'b0, dry_gain});
        wet_prod <= del * $signed({1'b0, wet_gain});
      end
      if (cmd.lp) begin
        lane_out[ch] <= mix;
      end
      if (cmd.fb) begin
        fb_prod <= lp * $signed({1'b0, feedback_gain});
      end
      if (cmd.tab) begin
        tab_a   <= ta;
        tab_d   <= $signed({tb[15], tb}) - $signed({ta[15], ta});
        tab_f   <= u[8:0];
        clip_lo <= (x < -18'sd65536);
        clip_hi <= (x >= 18'sd65536);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= {lane_out[1], lane_out[0]};
    end
  end

endmodule

[hdl/stereo_feedback_delay_lowpass.sv]
// top level of the stereo feedback delay with a lowpass in the feedback path
// depends on sfdl_pkg, sfdl_ctrl, sfdl_datapath and sfdl_ram
//
// Each stereo item (left and right Q1.15 samples) reads a delayed sample per
// channel from its delay store, moves a one-pole lowpass toward it, writes
// tanh(input + lowpass * feedback) back at the shared write position, and
// returns input * dry + delayed * wet, rounded and saturated to 16 bits. The
// result lands in the output register with the store write, or once the
// output register is free, after the accept and store read, lowpass/mix
// products, lowpass update, feedback product, table lookup and interpolation
// steps. The sequencer then returns to idle, or waits in its hold state while
// a result still waits on the master side, so an item is taken only once the
// one before it is through. A stalled master side adds the stall cycles once
// the next item reaches its store write. The stores need no clearing pass
// after reset: a wrap flag on the write position makes entries that were
// never written read as zero, so items are accepted right after reset.
// Configuration must be written only while no item is in flight; the block
// itself does not enforce this.
module stereo_feedback_delay_lowpass #(
  parameter int DELAY_DEPTH = sfdl_pkg::DELAY_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write port
  input  logic                           cfg_wr_en,
  input  logic [sfdl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfdl_pkg::CFG_W-1:0]     cfg_data,
  // input items
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [31:0]                    s_tdata,   // in_left [15:0], in_right [31:16]
  // result items
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [31:0]                    m_tdata    // out_left [15:0], out_right [31:16]
);
  import sfdl_pkg::*;

  dp_cmd_t cmd;

  // sequencer: one item at a time, one state per datapath step
  sfdl_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .cmd     (cmd)
  );

  // both channels run side by side, each with its own store and lowpass
  sfdl_datapath #(
    .DELAY_DEPTH(DELAY_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_data  (s_tdata),
    .out_data (m_tdata),
    .cmd      (cmd)
  );

  // an accepted item blocks the input for its whole sequence
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while an item is in flight");

  // the store write follows acceptance after the read, lowpass, feedback and table steps
  a_write_follows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_in |-> ##5 cmd.write)
    else $error("store write out of sequence");

  // datapath steps never overlap
  a_steps_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_in, cmd.mult, cmd.lp, cmd.fb, cmd.tab, cmd.write}))
    else $error("overlapping datapath steps");

  // a loaded result is offered on the next cycle
  a_result_offered: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> m_tvalid)
    else $error("loaded result not offered");

endmodule

[bench/stereo_delay_checker.sv]
// checker for the stereo feedback delay: watches the config port and both item channels,
// predicts every result and compares it with what the block returns
// depends on sfdl_pkg for the register index names
`timescale 1ns / 1ps

module stereo_delay_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  output int          mismatches,
  output int          pending
);
  import sfdl_pkg::*;

  localparam int DEPTH = 131072;
  localparam longint UNITY_Q24 = 64'sd16777216;
  localparam longint EXP_STEP = 64'sd17309782;

  // one stereo sample pair, left in the low half
  typedef struct packed {
    logic signed [15:0] right;
    logic signed [15:0] left;
  } stereo_t;

  // predictor state
  logic signed [15:0] echo_mem [2][DEPTH];
  longint             lp_state [2];
  logic [16:0]        wr_pos;
  logic [16:0]        delay_reg [2];
  logic [14:0]        fb_gain;
  logic [14:0]        lp_coeff;
  logic [15:0]        dry_gain;
  logic [15:0]        wet_gain;
  longint             tanh_pts [257];

  stereo_t expected_mix [$];
  int      fail_total = 0;

  // tanh points over [-2,2] in steps of 1/64, odd symmetric around the middle
  initial begin
    longint growth;
    longint half;
    growth = UNITY_Q24;
    tanh_pts[128] = 0;
    for (int k = 1; k <= 128; k++) begin
      growth = (growth * EXP_STEP) >>> 24;
      half = ((growth - UNITY_Q24) * 65536 + (growth + UNITY_Q24)) / (2 * (growth + UNITY_Q24));
      tanh_pts[128 + k] = half;
      tanh_pts[128 - k] = -half;
    end
  end

  function automatic longint soft_clip(input longint x);
    longint u;
    longint a;
    longint b;
    if (x < -65536) return tanh_pts[0];
    if (x >= 65536) return tanh_pts[256];
    u = x + 65536;
    a = tanh_pts[u >> 9];
    b = tanh_pts[(u >> 9) + 1];
    return a + (((b - a) * (u & 511)) >>> 9);
  endfunction

  function automatic logic signed [15:0] channel_step(input int ch, input longint smp);
    longint dly;
    longint rd;
    longint tap;
    longint diff;
    longint feed;
    longint mixed;
    dly = longint'(delay_reg[ch]);
    if (dly < 1) dly = 1;
    if (dly >= DEPTH) dly = DEPTH - 1;
    rd = (longint'(wr_pos) >= dly) ? longint'(wr_pos) - dly : longint'(wr_pos) + DEPTH - dly;
    tap = echo_mem[ch][rd];
    diff = tap * 256 - lp_state[ch];
    lp_state[ch] = lp_state[ch] + ((diff * longint'(lp_coeff)) >>> 15);
    feed = smp + ((lp_state[ch] * longint'(fb_gain)) >>> 23);
    echo_mem[ch][wr_pos] = 16'(soft_clip(feed));
    mixed = (smp * longint'(dry_gain) + tap * longint'(wet_gain) + 16384) >>> 15;
    if (mixed > 32767) mixed = 32767;
    if (mixed < -32768) mixed = -32768;
    return 16'(mixed);
  endfunction

  function automatic stereo_t predict_pair(input stereo_t pair);
    stereo_t res;
    res.left  = channel_step(0, longint'(pair.left));
    res.right = channel_step(1, longint'(pair.right));
    wr_pos = wr_pos + 17'd1;
    return res;
  endfunction

  always @(posedge clk) begin
    stereo_t got;
    stereo_t want;
    if (rst) begin
      foreach (echo_mem[c, a]) echo_mem[c][a] = '0;
      lp_state[0] = 0;
      lp_state[1] = 0;
      wr_pos = '0;
      delay_reg[0] = 17'd9084;
      delay_reg[1] = 17'd9901;
      fb_gain = 15'd4424;
      lp_coeff = 15'd22282;
      dry_gain = 16'd27034;
      wet_gain = 16'd11469;
      expected_mix.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_idx_t'(cfg_index))
          REG_DELAY_LEFT:    delay_reg[0] = cfg_data[16:0];
          REG_DELAY_RIGHT:   delay_reg[1] = cfg_data[16:0];
          REG_FEEDBACK_GAIN: fb_gain = cfg_data[14:0];
          REG_LOWPASS_COEFF: lp_coeff = cfg_data[14:0];
          REG_DRY_GAIN:      dry_gain = cfg_data[15:0];
          REG_WET_GAIN:      wet_gain = cfg_data[15:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got = stereo_t'(m_tdata);
        if (expected_mix.size() == 0) begin
          $error("result item with nothing expected: out_left %0d out_right %0d",
                 got.left, got.right);
          fail_total++;
        end else begin
          want = expected_mix.pop_front();
          if (got.left !== want.left) begin
            $error("out_left expected %0d actual %0d", want.left, got.left);
            fail_total++;
          end
          if (got.right !== want.right) begin
            $error("out_right expected %0d actual %0d", want.right, got.right);
            fail_total++;
          end
        end
      end
      if (s_tvalid && s_tready)
        expected_mix.push_back(predict_pair(stereo_t'(s_tdata)));
    end
    mismatches <= fail_total;
    pending <= expected_mix.size();
  end

endmodule

[bench/tb_stereo_feedback_delay_lowpass.sv]
// top of the stereo feedback delay testbench: clock, reset, config writes and item stimulus
// depends on sfdl_pkg, the block stereo_feedback_delay_lowpass and stereo_delay_checker
`timescale 1ns / 1ps

module tb_stereo_feedback_delay_lowpass;
  import sfdl_pkg::*;

  localparam int SEGMENTS = 9;
  localparam int SEGMENT_ITEMS = 128;
  // indexes past the last register, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [31:0]          s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [31:0]          m_tdata;

  int send_idle_pct = 8;
  int recv_idle_pct = 49;
  int mismatches;
  int pending;

  always #1 clk = ~clk;

  stereo_feedback_delay_lowpass i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  stereo_delay_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // result side stalls at random, rate set per phase
  always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_idle_pct);

  // one register write, only called with nothing in flight
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic write_all(input logic [16:0] dl, input logic [16:0] dr, input logic [14:0] fb,
                           input logic [14:0] lp, input logic [15:0] dry, input logic [15:0] wet);
    write_reg(REG_DELAY_LEFT, dl);
    write_reg(REG_DELAY_RIGHT, dr);
    write_reg(REG_FEEDBACK_GAIN, 17'(fb));
    write_reg(REG_LOWPASS_COEFF, 17'(lp));
    write_reg(REG_DRY_GAIN, 17'(dry));
    write_reg(REG_WET_GAIN, 17'(wet));
  endtask

  // present one stereo item with a random gap in front, return at the accepting edge
  task automatic send_pair(input logic [15:0] l, input logic [15:0] r);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {r, l};
    do @(posedge clk); while (!s_tready);
  endtask

  // stop sending and hold off until every result is back
  task automatic drain;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  // sample mix: full scale, silence for the echoes to ring out, quiet and loud noise
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(9))
      0: return $urandom_range(1) ? 16'h7fff : 16'h8000;
      1, 2: return 16'h0000;
      3: return 16'($signed($urandom_range(512)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  // short delays most of the time so the feedback path comes round within a phase
  function automatic logic [16:0] pick_delay();
    case ($urandom_range(9))
      0: return 17'd0;
      1: return 17'd131071;
      2: return 17'($urandom_range(131071));
      3: return 17'd1;
      default: return 17'($urandom_range(48, 2));
    endcase
  endfunction

  // gain register: stated bounds, zero, all ones beyond the range, or inside the range
  function automatic logic [16:0] pick_gain(input int lo, input int hi, input int full);
    case ($urandom_range(7))
      0: return 17'(lo);
      1: return 17'(hi);
      2: return 17'(full);
      3: return 17'd0;
      default: return 17'($urandom_range(hi, lo));
    endcase
  endfunction

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings, full-scale and near-zero items
    send_pair(16'h7fff, 16'h8000);
    send_pair(16'h8000, 16'h7fff);
    send_pair(16'h0000, 16'h0000);
    send_pair(16'hffff, 16'h0001);

    // zero delay acts as one, shortest loop with strongest stated feedback,
    // spare register indexes must leave everything alone
    drain;
    write_all(17'd0, 17'd1, 15'd29491, 15'd31130, 16'd32768, 16'd32768);
    write_reg(REG_SPARE_LO, 17'h1ffff);
    write_reg(REG_SPARE_HI, 17'h00000);
    for (int n = 0; n < 6; n++)
      send_pair(n[0] ? 16'h8000 : 16'h7fff, n[0] ? 16'h7fff : 16'h8000);

    // gains beyond unity to force saturation, longest left delay
    drain;
    write_all(17'd131071, 17'd2, 15'd32767, 15'd32767, 16'd65535, 16'd65535);
    send_pair(16'h7fff, 16'h7fff);
    send_pair(16'h8000, 16'h8000);
    send_pair(16'h5555, 16'haaaa);
    send_pair(16'haaaa, 16'h5555);
    send_pair(16'h7fff, 16'h8000);
    send_pair(16'h0000, 16'h0000);

    // no feedback, frozen lowpass, half dry and no wet, longest right delay
    drain;
    write_all(17'd1, 17'd131071, 15'd0, 15'd0, 16'd16384, 16'd0);
    send_pair(16'h7fff, 16'h8000);
    send_pair(16'h8000, 16'h7fff);
    send_pair(16'h0001, 16'hffff);
    send_pair(16'h1234, 16'hedcb);

    // random phases: sender lightly idle first, then receiver, then no idling at all
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      drain;
      case (seg / 3)
        0: begin
          send_idle_pct = 8;
          recv_idle_pct = 49;
        end
        1: begin
          send_idle_pct = 49;
          recv_idle_pct = 8;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_all(pick_delay(), pick_delay(), 15'(pick_gain(0, 29491, 32767)),
                15'(pick_gain(1638, 31130, 32767)), 16'(pick_gain(16384, 32768, 65535)),
                16'(pick_gain(0, 32768, 65535)));
      for (int n = 0; n < SEGMENT_ITEMS; n++)
        send_pair(pick_sample(), pick_sample());
    end

    // all results back, then a wait for anything stray
    drain;
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[files.f]
hdl/sfdl_pkg.sv
hdl/sfdl_ram.sv
hdl/sfdl_ctrl.sv
hdl/sfdl_datapath.sv
hdl/stereo_feedback_delay_lowpass.sv
bench/stereo_delay_checker.sv
bench/tb_stereo_feedback_delay_lowpass.sv
